// ===== hdl/ms_pkg.sv =====
// ----------------------------------------------------------------------------
// ms_pkg
// Shared constants and controller/datapath command and status types for the
// merge sorter.
// ----------------------------------------------------------------------------
package ms_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int DATA_W    = 32;

    // controller -> datapath
    typedef struct packed {
        logic load;       // input transfer this cycle
        logic init;       // set up first merge pass
        logic merge;      // one merge step
        logic emit_addr;  // read port 0 at the emit index
        logic emit_load;  // capture result into the output register
        logic finish;     // run complete, clear count and drop flag
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic passes_done;  // run width already covers the set
        logic pass_end;     // this merge step ends a pass
        logic out_final;    // result in the output register ends the run
    } status_t;

endpackage

// ===== hdl/ms_in_if.sv =====
// ----------------------------------------------------------------------------
// ms_in_if
// Input channel of the merge sorter: one value per transfer, last marks the
// end of the set.
// ----------------------------------------------------------------------------
interface ms_in_if;

    logic                              valid;
    logic                              ready;
    logic signed [ms_pkg::DATA_W-1:0]  value;
    logic                              last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);

endinterface

// ===== hdl/ms_out_if.sv =====
// ----------------------------------------------------------------------------
// ms_out_if
// Output channel of the merge sorter: one sorted value per transfer.
// ----------------------------------------------------------------------------
interface ms_out_if;

    logic                              valid;
    logic                              ready;
    logic signed [ms_pkg::DATA_W-1:0]  sorted_value;
    logic                              final_res;
    logic                              overflow;

    modport source (output valid, output sorted_value, output final_res,
                    output overflow, input ready);
    modport sink   (input valid, input sorted_value, input final_res,
                    input overflow, output ready);

endinterface

// ===== hdl/ms_datapath.sv =====
// ----------------------------------------------------------------------------
// ms_datapath
// Two ping-pong stores, merge index arithmetic, compare/select and the
// output register.
// ----------------------------------------------------------------------------
module ms_datapath #(
    parameter int MAX_ITEMS = ms_pkg::MAX_ITEMS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ms_pkg::cmd_t                     cmd,
    output ms_pkg::status_t                  status,
    input  logic signed [ms_pkg::DATA_W-1:0] value,
    output logic signed [ms_pkg::DATA_W-1:0] sorted_value,
    output logic                             final_res,
    output logic                             overflow
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);   // counts 0..MAX_ITEMS
    localparam int WW = CW + 1;                  // run width, up to < 2*MAX
    localparam int SW = CW + 2;                  // index sums
    localparam int DW = ms_pkg::DATA_W;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ITEMS);

    logic [DW-1:0] mem_a [MAX_ITEMS];
    logic [DW-1:0] mem_b [MAX_ITEMS];

    logic [DW-1:0] rd0_a_reg, rd1_a_reg, rd0_b_reg, rd1_b_reg;

    logic [CW-1:0] count_reg, count_next;
    logic          dropped_reg, dropped_next;
    logic [WW-1:0] width_reg, width_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] k_reg, k_next;
    logic          src_sel_reg, src_sel_next;   // 0: runs in A, 1: runs in B

    logic [DW-1:0] out_value_reg;
    logic          out_final_reg;
    logic          out_ovf_reg;

    logic [SW-1:0] n_ext, w_ext, w2, lo_ext, i_ext, j_ext, k_ext, k1;
    logic [SW-1:0] mid_raw, mid, hi_raw, hi, hpw_raw, hpw, w2_min;
    logic [DW-1:0] src_d0, src_d1, merge_data;
    logic          take_left, seg_end, pass_end, full;
    logic [AW-1:0] raddr0, raddr1, waddr_a;
    logic [DW-1:0] wdata_a;
    logic          wr_a, wr_b;

    // ---------------- index arithmetic ----------------
    always_comb
    begin
        n_ext   = SW'(count_reg);
        w_ext   = SW'(width_reg);
        w2      = w_ext << 1;
        lo_ext  = SW'(lo_reg);
        i_ext   = SW'(i_reg);
        j_ext   = SW'(j_reg);
        k_ext   = SW'(k_reg);
        k1      = k_ext + SW'(1);
        mid_raw = lo_ext + w_ext;
        mid     = (mid_raw > n_ext) ? n_ext : mid_raw;
        hi_raw  = lo_ext + w2;
        hi      = (hi_raw > n_ext) ? n_ext : hi_raw;
        hpw_raw = hi + w_ext;
        hpw     = (hpw_raw > n_ext) ? n_ext : hpw_raw;
        w2_min  = (w2 > n_ext) ? n_ext : w2;
        seg_end  = (k1 == hi);
        pass_end = (k1 == n_ext);
        full     = (count_reg >= MAX_C);

        src_d0 = src_sel_reg ? rd0_b_reg : rd0_a_reg;
        src_d1 = src_sel_reg ? rd1_b_reg : rd1_a_reg;
        // stable: ties go to the left run
        take_left  = (i_ext < mid) &&
                     ((j_ext >= hi) || ($signed(src_d0) <= $signed(src_d1)));
        merge_data = take_left ? src_d0 : src_d1;
    end

    // ---------------- next state ----------------
    always_comb
    begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        width_next   = width_reg;
        lo_next      = lo_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        src_sel_next = src_sel_reg;

        if (cmd.load)
        begin
            if (full)
                dropped_next = 1'b1;
            else
                count_next = count_reg + CW'(1);
        end

        if (cmd.init)
        begin
            width_next   = WW'(1);
            lo_next      = '0;
            i_next       = '0;
            j_next       = (count_reg != '0) ? CW'(1) : '0;
            k_next       = '0;
            src_sel_next = 1'b0;
        end
        else if (cmd.merge)
        begin
            if (pass_end)
            begin
                width_next   = WW'(w2);
                lo_next      = '0;
                i_next       = '0;
                j_next       = CW'(w2_min);
                k_next       = '0;
                src_sel_next = ~src_sel_reg;
            end
            else if (seg_end)
            begin
                lo_next = CW'(hi);
                i_next  = CW'(hi);
                j_next  = CW'(hpw);
                k_next  = CW'(k1);
            end
            else
            begin
                i_next = take_left ? CW'(i_ext + SW'(1)) : i_reg;
                j_next = take_left ? j_reg : CW'(j_ext + SW'(1));
                k_next = CW'(k1);
            end
        end
        else if (cmd.emit_load)
        begin
            k_next = CW'(k1);
        end
        else if (cmd.finish)
        begin
            k_next       = '0;
            count_next   = '0;
            dropped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            width_reg   <= '0;
            lo_reg      <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            src_sel_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            width_reg   <= width_next;
            lo_reg      <= lo_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            src_sel_reg <= src_sel_next;
        end
    end

    // ---------------- stores ----------------
    // merge steps read at the next indices so data is ready every cycle
    always_comb
    begin
        if (cmd.merge)
        begin
            raddr0 = i_next[AW-1:0];
            raddr1 = j_next[AW-1:0];
        end
        else if (cmd.emit_addr)
        begin
            raddr0 = k_reg[AW-1:0];
            raddr1 = j_reg[AW-1:0];
        end
        else
        begin
            raddr0 = i_reg[AW-1:0];
            raddr1 = j_reg[AW-1:0];
        end

        wr_a    = (cmd.load && !full) || (cmd.merge && src_sel_reg);
        wr_b    = cmd.merge && !src_sel_reg;
        waddr_a = cmd.load ? count_reg[AW-1:0] : k_reg[AW-1:0];
        wdata_a = cmd.load ? DW'(value) : merge_data;
    end

    always_ff @(posedge clk)
    begin
        if (wr_a)
            mem_a[waddr_a] <= wdata_a;
        rd0_a_reg <= mem_a[raddr0];
        rd1_a_reg <= mem_a[raddr1];
    end

    always_ff @(posedge clk)
    begin
        if (wr_b)
            mem_b[k_reg[AW-1:0]] <= merge_data;
        rd0_b_reg <= mem_b[raddr0];
        rd1_b_reg <= mem_b[raddr1];
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            out_value_reg <= src_d0;
            out_final_reg <= pass_end;
            out_ovf_reg   <= dropped_reg;
        end
    end

    assign sorted_value       = $signed(out_value_reg);
    assign final_res          = out_final_reg;
    assign overflow           = out_ovf_reg;
    assign status.passes_done = (w_ext >= n_ext);
    assign status.pass_end    = pass_end;
    assign status.out_final   = out_final_reg;

    // ---------------- assertions ----------------
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_C)
        else $error("element count above capacity");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        dropped_reg |-> (count_reg == MAX_C))
        else $error("drop flag set while store not full");

    a_merge_idx: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.merge |-> (k_ext < n_ext) && (i_ext <= mid) && (j_ext <= hi)
                      && (lo_ext <= i_ext))
        else $error("merge indices out of run bounds");

    a_emit_idx: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_load |-> (k_reg < count_reg))
        else $error("emit index past end of set");

endmodule

// ===== hdl/ms_ctrl.sv =====
// ----------------------------------------------------------------------------
// ms_ctrl
// Sequencer: load, merge passes, emit with handshake.
// ----------------------------------------------------------------------------
module ms_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_last,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  ms_pkg::status_t status,
    output ms_pkg::cmd_t    cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INIT    = 3'd1;
    localparam logic [2:0] S_PRIME   = 3'd2;
    localparam logic [2:0] S_MERGE   = 3'd3;
    localparam logic [2:0] S_EMIT_RD = 3'd4;
    localparam logic [2:0] S_EMIT_LD = 3'd5;
    localparam logic [2:0] S_HOLD    = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       in_xfer, out_xfer;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_HOLD);
    assign in_xfer   = in_valid && in_ready;
    assign out_xfer  = out_valid && out_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_xfer;
                if (in_xfer && in_last)
                    state_next = S_INIT;
            end
            S_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = S_PRIME;
            end
            S_PRIME:
            begin
                // first reads of the pass are in flight; the last write of
                // the previous pass has landed
                state_next = status.passes_done ? S_EMIT_RD : S_MERGE;
            end
            S_MERGE:
            begin
                cmd.merge = 1'b1;
                if (status.pass_end)
                    state_next = S_PRIME;
            end
            S_EMIT_RD:
            begin
                cmd.emit_addr = 1'b1;
                state_next    = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                cmd.emit_load = 1'b1;
                state_next    = S_HOLD;
            end
            S_HOLD:
            begin
                if (out_xfer)
                begin
                    cmd.finish = status.out_final;
                    state_next = status.out_final ? S_IDLE : S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== hdl/merge_sorter.sv =====
// ----------------------------------------------------------------------------
// merge_sorter
// Collects a set of signed 32-bit values and returns it in ascending order
// using a stable bottom-up merge sort.
// ----------------------------------------------------------------------------
// Values arrive one per transfer on items; the transfer with last set closes
// the set. Up to MAX_ITEMS values are kept, later ones are dropped and every
// result of that run then carries overflow. Values are accepted back to back
// while loading. After last, items.ready stays low until the final result
// has been taken: after an init state and a first prime state, the sort runs
// ceil(log2 n) merge passes of n merge steps each (one merge step per cycle,
// bounded by the single write port of the destination store), each pass
// followed by a prime state that refills the store read registers, and each
// result then passes through a store read, an output register load and a
// transfer that waits for results.ready. Results are returned in ascending
// order; equal values keep their arrival order, and final_res marks the last
// one.
// ----------------------------------------------------------------------------
module merge_sorter #(
    parameter int MAX_ITEMS = ms_pkg::MAX_ITEMS
) (
    input  logic     clk,
    input  logic     rst_n,
    ms_in_if.sink    items,
    ms_out_if.source results
);

    ms_pkg::cmd_t    cmd;
    ms_pkg::status_t status;

    // sequencer: owns both handshakes
    ms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_last   (items.last),
        .in_ready  (items.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // stores, merge arithmetic and output register
    ms_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .value        (items.value),
        .sorted_value (results.sorted_value),
        .final_res    (results.final_res),
        .overflow     (results.overflow)
    );

endmodule
